/* src/radius_to_float_code_top_assert.svh */
// ----------------------------------------------------------------------------
// radius_to_float_code_top_assert.svh
// Assertion macros used by the radius-to-float-code top level.
// ----------------------------------------------------------------------------
`ifndef RADIUS_TO_FLOAT_CODE_TOP_ASSERT_SVH
`define RADIUS_TO_FLOAT_CODE_TOP_ASSERT_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define RTFC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond must hold at every clock edge outside reset.
`define RTFC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

/* src/rtfc_pkg.sv */
// ----------------------------------------------------------------------------
// rtfc_pkg
// Types and constants shared by the radius-to-float-code pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtfc_pkg;

  localparam int unsigned RadiusW  = 15;
  localparam int unsigned ScaleMulW = 13;
  localparam int unsigned ProductW = RadiusW + ScaleMulW;
  localparam int unsigned ScaleShift = 10;
  // scaled value tops out at 219033, which needs 18 bits
  localparam int unsigned ScaledW  = ProductW - ScaleShift;
  localparam int unsigned NormW    = 17;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned ExpoW    = 4;
  localparam int unsigned MantW    = 8;
  localparam int unsigned CodeW    = 16;

  localparam logic [ScaleMulW-1:0] SCALE_MUL   = 13'd6845;
  localparam logic [NormW-1:0]     ROUND_HALF  = 17'h00080;
  localparam logic [MantW-1:0]     MANT_MAX    = 8'hFF;
  localparam logic [CodeW-1:0]     CODE_ERROR  = 16'h0000;
  localparam logic [ExpoW-1:0]     EXPO_BASE   = 4'd1;

  // word leaving the scaling stage
  typedef struct packed {
    logic [ScaledW-1:0] scaled;
    logic               zero;
  } scale_word_t;

  // word leaving the leading-one stage
  typedef struct packed {
    logic [ScaledW-1:0] scaled;
    logic               shr;     // value too large: halve once
    logic [ShiftW-1:0]  shl;     // left doublings needed
    logic [ExpoW-1:0]   expo;
    logic               zero;
  } lod_word_t;

endpackage

`default_nettype wire

/* src/radius_to_float_code_top.sv */
// ----------------------------------------------------------------------------
// radius_to_float_code_top
// Converts a 15-bit radius into a 16-bit floating-style code.
//
// Input channel: in_valid_i / in_ready_o carry one radius word on
// radius_in_i. Output channel: out_valid_o / out_ready_i carry one result
// word on float_code_o and zero_error_o. A word moves when valid and ready
// are both high at a rising edge.
// Pipeline: three register stages (scale multiplier, leading-one detector,
// normalize/round). An accepted radius passes through these registers in
// that order, and its result shows on out_valid_o from the last one.
// Throughput: one word per cycle while out_ready_i stays high; each stage
// register hands on as soon as the next one frees up.
// A zero radius gives float_code 0 with zero_error set.
// Reset clears all stage valid bits; the pipeline is empty afterwards.
// When the receiver holds out_ready_i low, the words stay in their stages
// and in_ready_o drops once all three stages are full; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radius_to_float_code_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [rtfc_pkg::RadiusW-1:0] radius_in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [rtfc_pkg::CodeW-1:0]        float_code_o,
  output logic                              zero_error_o
);
  import rtfc_pkg::*;

  `include "radius_to_float_code_top_assert.svh"

  logic        s1_valid, s1_ready;
  scale_word_t s1_word;
  logic        s2_valid, s2_ready;
  lod_word_t   s2_word;
  logic        err_word, code_word, code_shape_ok, full_stall;

  // stage 1: scaling
  rtfc_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .radius_i (radius_in_i),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .word_o   (s1_word)
  );

  // stage 2: leading-one detection
  rtfc_lod u_lod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .word_i  (s1_word),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .word_o  (s2_word)
  );

  // stage 3: normalize, round, pack
  rtfc_norm u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s2_valid),
    .ready_o      (s2_ready),
    .word_i       (s2_word),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .float_code_o (float_code_o),
    .zero_error_o (zero_error_o)
  );

  // output word classes for the checks below
  assign err_word      = out_valid_o && zero_error_o;
  assign code_word     = out_valid_o && !zero_error_o;
  assign code_shape_ok = float_code_o[CodeW-1] && (float_code_o[3:0] == 4'h0);
  assign full_stall    = out_valid_o && !out_ready_i && s1_valid && s2_valid;

  // the error word carries no code
  `RTFC_ASSERT_IMPLIES(a_err_code_zero, clk_i, rst_ni, err_word, float_code_o == CODE_ERROR, "error word")
  // a valid code always has bit 15 set and a clear low nibble
  `RTFC_ASSERT_IMPLIES(a_code_shape, clk_i, rst_ni, code_word, code_shape_ok, "malformed code")
  // input only backs up when every stage is full and the output is stalled
  `RTFC_ASSERT_ALWAYS(a_backpressure, clk_i, rst_ni, in_ready_o || full_stall, "early stall")

endmodule

`default_nettype wire

/* src/rtfc_scale.sv */
// ----------------------------------------------------------------------------
// rtfc_scale
// Stage 1: scales the radius by 6845/1024 (floor) and flags a zero radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtfc_scale (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [rtfc_pkg::RadiusW-1:0] radius_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output rtfc_pkg::scale_word_t             word_o
);
  import rtfc_pkg::*;

  logic                valid_q;
  scale_word_t         word_q, word_d;
  logic [ProductW-1:0] product;

  assign ready_o = !valid_q || ready_i;

  // 15x13 multiply; dropping the low bits divides by 1024
  always_comb begin
    product       = ProductW'(radius_i) * ProductW'(SCALE_MUL);
    word_d.scaled = product[ProductW-1:ScaleShift];
    word_d.zero   = (radius_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

/* src/rtfc_lod.sv */
// ----------------------------------------------------------------------------
// rtfc_lod
// Stage 2: leading-one detection on the scaled value; picks the shift
// direction, the shift amount and the exponent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtfc_lod (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire rtfc_pkg::scale_word_t word_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output rtfc_pkg::lod_word_t        word_o
);
  import rtfc_pkg::*;

  logic      valid_q;
  lod_word_t word_q, word_d;

  assign ready_o = !valid_q || ready_i;

  // leading one in bits 16..0 gives the left shift; bit 17 means halve once
  always_comb begin
    word_d.scaled = word_i.scaled;
    word_d.zero   = word_i.zero;
    word_d.shr    = word_i.scaled[ScaledW-1];
    word_d.shl    = ShiftW'(NormW - 1);
    for (int i = 0; i < NormW; i++) begin
      if (word_i.scaled[i]) begin
        word_d.shl = ShiftW'(NormW - 1 - i);
      end
    end
    if (word_d.shr) begin
      word_d.shl  = '0;
      word_d.expo = EXPO_BASE - 4'd1;
    end else begin
      word_d.expo = EXPO_BASE + word_d.shl[ExpoW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

/* src/rtfc_norm.sv */
// ----------------------------------------------------------------------------
// rtfc_norm
// Stage 3: normalizes into [65536,131072), rounds the mantissa half up with
// a clamp at 255 and packs the output code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtfc_norm (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire rtfc_pkg::lod_word_t        word_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic [rtfc_pkg::CodeW-1:0]      float_code_o,
  output logic                            zero_error_o
);
  import rtfc_pkg::*;

  logic             valid_q;
  logic [CodeW-1:0] code_q, code_d;
  logic             err_q;
  logic [NormW-1:0] norm;
  logic [NormW-1:0] rsum;
  logic [MantW-1:0] mant;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // normalize: halving truncates the low bit
    if (word_i.shr) begin
      norm = word_i.scaled[ScaledW-1:1];
    end else begin
      norm = word_i.scaled[NormW-1:0] << word_i.shl;
    end
    // fraction below the leading one, rounded half up
    rsum = {1'b0, norm[NormW-2:0]} + ROUND_HALF;
    mant = rsum[NormW-1] ? MANT_MAX : rsum[NormW-2:NormW-1-MantW];
    if (word_i.zero) begin
      code_d = CODE_ERROR;
    end else begin
      code_d = {1'b1, word_i.expo[ExpoW-2:0], mant, 4'h0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      code_q <= code_d;
      err_q  <= word_i.zero;
    end
  end

  assign valid_o      = valid_q;
  assign float_code_o = code_q;
  assign zero_error_o = err_q;

endmodule

`default_nettype wire
